// ----- hw/rtl/world_to_screen_projection_unit_assert.svh -----
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit_assert
// assertion macros used by the projection unit rtl
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_ASSERT_SVH

// checked on every edge outside reset
`define WSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WSP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg
// constants, types and register codes of the projection unit
// ----------------------------------------------------------------------------
package wsp_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int COEF_BITS  = 32;
	localparam int CFG_BITS   = 64;
	localparam int VP_BITS    = 15;
	localparam int IDX_BITS   = 3;
	localparam int NUM_COEFS  = 12;
	localparam int NUM_ROWS   = 6;

	// exact product, rounded row sum, magnitudes and divider widths
	localparam int PROD_BITS = COEF_BITS + COORD_BITS;
	localparam int ROW_BITS  = PROD_BITS - FRAC_BITS + 1;
	localparam int MAG_BITS  = ROW_BITS + 1;
	localparam int REM_BITS  = MAG_BITS + 1;
	localparam int NUM_BITS  = MAG_BITS + VP_BITS;
	localparam int SH_BITS   = NUM_BITS + FRAC_BITS - 1;
	localparam int HI_BITS   = SH_BITS - COORD_BITS;

	localparam logic [CFG_BITS-1:0] ROW_X_LO_RST = 64'h0000_0000_0001_0000;
	localparam logic [CFG_BITS-1:0] ROW_X_HI_RST = 64'h0;
	localparam logic [CFG_BITS-1:0] ROW_Y_LO_RST = 64'h0001_0000_0000_0000;
	localparam logic [CFG_BITS-1:0] ROW_Y_HI_RST = 64'h0;
	localparam logic [CFG_BITS-1:0] ROW_W_LO_RST = 64'h0;
	localparam logic [CFG_BITS-1:0] ROW_W_HI_RST = 64'h0001_0000_0000_0000;
	localparam logic [VP_BITS-1:0]  WIDTH_RST    = 15'd640;
	localparam logic [VP_BITS-1:0]  HEIGHT_RST   = 15'd480;

	typedef enum logic [IDX_BITS-1:0] {
		REG_ROW_X_LO      = 3'd0,
		REG_ROW_X_HI      = 3'd1,
		REG_ROW_Y_LO      = 3'd2,
		REG_ROW_Y_HI      = 3'd3,
		REG_ROW_W_LO      = 3'd4,
		REG_ROW_W_HI      = 3'd5,
		REG_SCREEN_WIDTH  = 3'd6,
		REG_SCREEN_HEIGHT = 3'd7
	} wsp_reg_t;

	// coefficient r*4+t: row r (x, y, w), term t (x, y, z, constant)
	typedef logic [NUM_COEFS-1:0][COEF_BITS-1:0] wsp_matrix_t;

	typedef struct packed {
		logic                deg;
		logic                neg_x;
		logic                neg_y;
		logic [MAG_BITS-1:0] mag_x;
		logic [MAG_BITS-1:0] mag_y;
		logic [MAG_BITS-1:0] d;
	} wsp_proj_t;

	typedef struct packed {
		logic                  deg;
		logic                  neg_x;
		logic                  neg_y;
		logic                  ovf_x;
		logic                  ovf_y;
		logic [MAG_BITS-1:0]   d;
		logic [REM_BITS-1:0]   rem_x;
		logic [REM_BITS-1:0]   rem_y;
		logic [COORD_BITS-1:0] lo_x;
		logic [COORD_BITS-1:0] lo_y;
		logic [COORD_BITS-1:0] q_x;
		logic [COORD_BITS-1:0] q_y;
	} wsp_div_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] screen_x;
		logic [COORD_BITS-1:0] screen_y;
		logic                  degenerate;
		logic                  overflowed;
	} wsp_result_t;

endpackage

// ----- hw/rtl/wsp_point_if.sv -----
// ----------------------------------------------------------------------------
// wsp_point_if
// input channel: one world-space point per item
// ----------------------------------------------------------------------------
interface wsp_point_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wsp_pkg::COORD_BITS-1:0] world_x;
	logic signed [wsp_pkg::COORD_BITS-1:0] world_y;
	logic signed [wsp_pkg::COORD_BITS-1:0] world_z;

	modport source (output valid, world_x, world_y, world_z, input ready);
	modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

// ----- hw/rtl/wsp_screen_if.sv -----
// ----------------------------------------------------------------------------
// wsp_screen_if
// output channel: one screen position per item
// ----------------------------------------------------------------------------
interface wsp_screen_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wsp_pkg::COORD_BITS-1:0] screen_x;
	logic signed [wsp_pkg::COORD_BITS-1:0] screen_y;
	logic                                  degenerate;
	logic                                  overflowed;

	modport source (output valid, screen_x, screen_y, degenerate, overflowed, input ready);
	modport sink (input valid, screen_x, screen_y, degenerate, overflowed, output ready);
endinterface

// ----- hw/rtl/wsp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// wsp_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface wsp_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [wsp_pkg::IDX_BITS-1:0]        index;
	logic [wsp_pkg::CFG_BITS-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/wsp_transform.sv -----
// ----------------------------------------------------------------------------
// wsp_transform
// matrix rows times point, rounding, row sums and divider set-up (3 stages)
// ----------------------------------------------------------------------------
module wsp_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [2:0][wsp_pkg::COORD_BITS-1:0] point,
	input  wsp_pkg::wsp_matrix_t                matrix,
	output logic                                out_valid,
	output wsp_pkg::wsp_proj_t                  proj
);
	localparam int PB = wsp_pkg::PROD_BITS;
	localparam int RB = wsp_pkg::ROW_BITS;
	localparam int MB = wsp_pkg::MAG_BITS;

	logic signed [PB-1:0] prod_s1 [9];
	logic                 valid_s1, valid_s2;
	logic signed [RB-1:0] row_s2 [3];

	function automatic logic signed [RB-1:0] round_prod(input logic signed [PB-1:0] p);
		logic signed [PB:0] q;
		q = $signed({p[PB-1], p}) + $signed((PB+1)'(1) << (wsp_pkg::FRAC_BITS - 1));
		return RB'(q >>> wsp_pkg::FRAC_BITS);
	endfunction

	function automatic logic [MB-1:0] mag(input logic signed [MB-1:0] v);
		return v[MB-1] ? MB'(-v) : MB'(v);
	endfunction

	logic signed [MB-1:0] num_x, num_y, w_ext;
	assign w_ext = MB'(row_s2[2]);
	assign num_x = MB'(row_s2[0]) + w_ext;
	assign num_y = w_ext - MB'(row_s2[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int t = 0; t < 3; t++) begin
					prod_s1[r*3+t] <= PB'($signed(matrix[r*4+t])) * PB'($signed(point[t]));
				end
			end
			for (int r = 0; r < 3; r++) begin
				row_s2[r] <= round_prod(prod_s1[r*3]) + round_prod(prod_s1[r*3+1])
					+ round_prod(prod_s1[r*3+2]) + RB'($signed(matrix[r*4+3]));
			end
			proj.deg   <= (row_s2[2] == '0);
			proj.neg_x <= num_x[MB-1] ^ w_ext[MB-1];
			proj.neg_y <= num_y[MB-1] ^ w_ext[MB-1];
			proj.mag_x <= mag(num_x);
			proj.mag_y <= mag(num_y);
			proj.d     <= mag(w_ext);
		end
	end
endmodule

// ----- hw/rtl/wsp_scale.sv -----
// ----------------------------------------------------------------------------
// wsp_scale
// viewport scaling and divider entry with high-quotient overflow check (2 stages)
// ----------------------------------------------------------------------------
module wsp_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  wsp_pkg::wsp_proj_t            proj,
	input  logic [wsp_pkg::VP_BITS-1:0]   width,
	input  logic [wsp_pkg::VP_BITS-1:0]   height,
	output logic                          out_valid,
	output wsp_pkg::wsp_div_t             div
);
	localparam int NB = wsp_pkg::NUM_BITS;
	localparam int SB = wsp_pkg::SH_BITS;
	localparam int HB = wsp_pkg::HI_BITS;
	localparam int CB = wsp_pkg::COORD_BITS;
	localparam int MB = wsp_pkg::MAG_BITS;

	logic               valid_s4;
	logic [NB-1:0]      n_x_s4, n_y_s4;
	wsp_pkg::wsp_proj_t proj_s4;

	logic [SB-1:0] sh_x, sh_y;
	logic [HB-1:0] hi_x, hi_y;
	logic          pre_x, pre_y;

	// numerator times 2^(frac-1); quotient bits above the output width only flag overflow
	assign sh_x  = {n_x_s4, (wsp_pkg::FRAC_BITS - 1)'(0)};
	assign sh_y  = {n_y_s4, (wsp_pkg::FRAC_BITS - 1)'(0)};
	assign hi_x  = sh_x[SB-1 -: HB];
	assign hi_y  = sh_y[SB-1 -: HB];
	assign pre_x = MB'(hi_x) >= proj_s4.d;
	assign pre_y = MB'(hi_y) >= proj_s4.d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s4  <= in_valid;
			out_valid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			proj_s4   <= proj;
			n_x_s4    <= NB'(proj.mag_x) * NB'(width);
			n_y_s4    <= NB'(proj.mag_y) * NB'(height);
			div.deg   <= proj_s4.deg;
			div.neg_x <= proj_s4.neg_x;
			div.neg_y <= proj_s4.neg_y;
			div.ovf_x <= pre_x;
			div.ovf_y <= pre_y;
			div.d     <= proj_s4.d;
			div.rem_x <= pre_x ? '0 : wsp_pkg::REM_BITS'(hi_x);
			div.rem_y <= pre_y ? '0 : wsp_pkg::REM_BITS'(hi_y);
			div.lo_x  <= sh_x[CB-1:0];
			div.lo_y  <= sh_y[CB-1:0];
			div.q_x   <= '0;
			div.q_y   <= '0;
		end
	end
endmodule

// ----- hw/rtl/wsp_div_step.sv -----
// ----------------------------------------------------------------------------
// wsp_div_step
// one restoring-division stage: one quotient bit for both lanes
// ----------------------------------------------------------------------------
module wsp_div_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  wsp_pkg::wsp_div_t din,
	output logic              out_valid,
	output wsp_pkg::wsp_div_t dout
);
	localparam int RB = wsp_pkg::REM_BITS;
	localparam int CB = wsp_pkg::COORD_BITS;

	logic [RB:0] r2_x, r2_y, dv;
	logic        ge_x, ge_y;
	logic [RB:0] nr_x, nr_y;

	wsp_pkg::wsp_div_t nxt;

	assign dv   = (RB+1)'(din.d);
	assign r2_x = {din.rem_x, din.lo_x[CB-1]};
	assign r2_y = {din.rem_y, din.lo_y[CB-1]};
	assign ge_x = r2_x >= dv;
	assign ge_y = r2_y >= dv;
	assign nr_x = ge_x ? r2_x - dv : r2_x;
	assign nr_y = ge_y ? r2_y - dv : r2_y;

	always_comb begin
		nxt       = din;
		nxt.rem_x = nr_x[RB-1:0];
		nxt.rem_y = nr_y[RB-1:0];
		nxt.lo_x  = {din.lo_x[CB-2:0], 1'b0};
		nxt.lo_y  = {din.lo_y[CB-2:0], 1'b0};
		nxt.q_x   = {din.q_x[CB-2:0], ge_x};
		nxt.q_y   = {din.q_y[CB-2:0], ge_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule

// ----- hw/rtl/wsp_finish.sv -----
// ----------------------------------------------------------------------------
// wsp_finish
// round to nearest, saturate, apply sign and the zero-w case (1 stage)
// ----------------------------------------------------------------------------
module wsp_finish (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  wsp_pkg::wsp_div_t    din,
	output logic                 out_valid,
	output wsp_pkg::wsp_result_t res
);
	localparam int CB = wsp_pkg::COORD_BITS;
	localparam int RB = wsp_pkg::REM_BITS;

	logic [CB-1:0] val_x, val_y;
	logic          ov_x, ov_y;

	function automatic logic [CB:0] lane(input logic [CB-1:0] q, input logic [RB-1:0] rem,
		input logic [wsp_pkg::MAG_BITS-1:0] d, input logic neg, input logic pre);
		logic          up;
		logic [CB:0]   qr, lim, v;
		logic          ov;
		up  = {rem, 1'b0} >= (RB+1)'(d);
		qr  = (CB+1)'(q) + (CB+1)'(up);
		lim = ((CB+1)'(1) << (CB - 1)) - (CB+1)'(!neg);
		ov  = pre || (qr > lim);
		v   = ov ? lim : qr;
		v   = neg ? (CB+1)'(-v) : v;
		return {ov, v[CB-1:0]};
	endfunction

	assign {ov_x, val_x} = lane(din.q_x, din.rem_x, din.d, din.neg_x, din.ovf_x);
	assign {ov_y, val_y} = lane(din.q_y, din.rem_y, din.d, din.neg_y, din.ovf_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.screen_x   <= din.deg ? '0 : val_x;
			res.screen_y   <= din.deg ? '0 : val_y;
			res.degenerate <= din.deg;
			res.overflowed <= !din.deg && (ov_x || ov_y);
		end
	end
endmodule

// ----- hw/rtl/world_to_screen_projection_unit.sv -----
// path: from point accepted to screen item valid through 3 transform, 2 scale,
// 32 division stages and 1 rounding stage; items wait longer only while the output stalls
// throughput: one item per cycle unless the output stalls; each of the 32 division stages retires one quotient bit
// reset: clears all valid bits and the output skid, loads the identity matrix and 640x480
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// homogeneous vertex projection with viewport mapping, fully pipelined
// ----------------------------------------------------------------------------
`include "world_to_screen_projection_unit_assert.svh"

module world_to_screen_projection_unit (
	input  logic                clk,
	input  logic                arst_n,
	wsp_cfg_if.sink             cfg,
	wsp_point_if.sink           point,
	wsp_screen_if.source        screen
);
	localparam int CB = wsp_pkg::COORD_BITS;
	localparam int CF = wsp_pkg::COEF_BITS;

	logic [wsp_pkg::NUM_ROWS-1:0][wsp_pkg::CFG_BITS-1:0] rows_q;
	logic [wsp_pkg::VP_BITS-1:0] width_q, height_q;
	wsp_pkg::wsp_matrix_t        matrix;

	logic                 en;
	logic                 skid_vq;
	wsp_pkg::wsp_result_t skid_q;

	logic                 proj_v, scale_v, fin_v;
	wsp_pkg::wsp_proj_t   proj;
	wsp_pkg::wsp_div_t    div_d [CB+1];
	logic                 div_v [CB+1];
	wsp_pkg::wsp_result_t fin_res, out_res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[wsp_pkg::REG_ROW_X_LO] <= wsp_pkg::ROW_X_LO_RST;
			rows_q[wsp_pkg::REG_ROW_X_HI] <= wsp_pkg::ROW_X_HI_RST;
			rows_q[wsp_pkg::REG_ROW_Y_LO] <= wsp_pkg::ROW_Y_LO_RST;
			rows_q[wsp_pkg::REG_ROW_Y_HI] <= wsp_pkg::ROW_Y_HI_RST;
			rows_q[wsp_pkg::REG_ROW_W_LO] <= wsp_pkg::ROW_W_LO_RST;
			rows_q[wsp_pkg::REG_ROW_W_HI] <= wsp_pkg::ROW_W_HI_RST;
			width_q  <= wsp_pkg::WIDTH_RST;
			height_q <= wsp_pkg::HEIGHT_RST;
		end else if (cfg.valid) begin
			case (wsp_pkg::wsp_reg_t'(cfg.index))
				wsp_pkg::REG_ROW_X_LO: rows_q[wsp_pkg::REG_ROW_X_LO] <= cfg.data;
				wsp_pkg::REG_ROW_X_HI: rows_q[wsp_pkg::REG_ROW_X_HI] <= cfg.data;
				wsp_pkg::REG_ROW_Y_LO: rows_q[wsp_pkg::REG_ROW_Y_LO] <= cfg.data;
				wsp_pkg::REG_ROW_Y_HI: rows_q[wsp_pkg::REG_ROW_Y_HI] <= cfg.data;
				wsp_pkg::REG_ROW_W_LO: rows_q[wsp_pkg::REG_ROW_W_LO] <= cfg.data;
				wsp_pkg::REG_ROW_W_HI: rows_q[wsp_pkg::REG_ROW_W_HI] <= cfg.data;
				wsp_pkg::REG_SCREEN_WIDTH: width_q <= cfg.data[wsp_pkg::VP_BITS-1:0];
				wsp_pkg::REG_SCREEN_HEIGHT: height_q <= cfg.data[wsp_pkg::VP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// each 64-bit register holds two coefficients, low half first
	always_comb begin
		for (int r = 0; r < wsp_pkg::NUM_ROWS; r++) begin
			matrix[r*2]   = rows_q[r][CF-1:0];
			matrix[r*2+1] = rows_q[r][2*CF-1:CF];
		end
	end

	// whole pipe advances while the skid stage is empty
	assign en          = !skid_vq;
	assign point.ready = en;

	wsp_transform u_transform (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (point.valid),
		.point     ({point.world_z, point.world_y, point.world_x}),
		.matrix    (matrix),
		.out_valid (proj_v),
		.proj      (proj)
	);

	wsp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (proj_v),
		.proj      (proj),
		.width     (width_q),
		.height    (height_q),
		.out_valid (scale_v),
		.div       (div_d[0])
	);

	assign div_v[0] = scale_v;

	for (genvar i = 0; i < CB; i++) begin : g_div
		wsp_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (div_v[i]),
			.din       (div_d[i]),
			.out_valid (div_v[i+1]),
			.dout      (div_d[i+1])
		);
	end

	wsp_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_v[CB]),
		.din       (div_d[CB]),
		.out_valid (fin_v),
		.res       (fin_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vq <= 1'b0;
		end else if (skid_vq) begin
			if (screen.ready) begin
				skid_vq <= 1'b0;
			end
		end else if (fin_v && !screen.ready) begin
			skid_vq <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vq) begin
			skid_q <= fin_res;
		end
	end

	assign out_res           = skid_vq ? skid_q : fin_res;
	assign screen.valid      = skid_vq || fin_v;
	assign screen.screen_x   = out_res.screen_x;
	assign screen.screen_y   = out_res.screen_y;
	assign screen.degenerate = out_res.degenerate;
	assign screen.overflowed = out_res.overflowed;

	`WSP_ASSERT(a_stall_has_item, !point.ready |-> screen.valid, "input stalled with no item pending")
	`WSP_ASSERT(a_skid_catches, (screen.valid && !screen.ready && !skid_vq) |=> skid_vq, "refused item not caught by skid")
	`WSP_ASSERT(a_degenerate_zero, (screen.valid && screen.degenerate) |-> (!screen.overflowed && screen.screen_x == '0 && screen.screen_y == '0), "zero-w item not forced to origin")
	`WSP_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !skid_vq, "skid not empty after reset")
endmodule
